/* rtl/u2da_pkg.sv */
// Shared types and constants for the unsigned to decimal ASCII converter.
`default_nettype none
package u2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = 4 * NUM_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = 5;

    localparam logic [CHAR_W-1:0] DIGIT_BASE = 6'd48;
    localparam logic [CNT_W-1:0]  LAST_STEP  = 5'(VALUE_W - 1);
    localparam logic [CNT_W-1:0]  TOP_DIGIT  = 5'(NUM_DIGITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic drop;
        logic emit;
        logic last;
    } t_dp_cmd;

    typedef struct packed {
        logic top_zero;
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

/* rtl/u2da_dp.sv */
// Datapath: shift-and-add-3 conversion register, digit shifter and output register.
`default_nettype none
module u2da_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire u2da_pkg::t_dp_cmd              i_cmd,
    output u2da_pkg::t_dp_status                o_status,
    input  wire logic [u2da_pkg::VALUE_W-1:0]   i_value,
    input  wire logic                           i_out_ready,
    output logic                                o_out_valid,
    output logic [u2da_pkg::CHAR_W-1:0]         o_out_char,
    output logic                                o_out_last
);

    logic [u2da_pkg::VALUE_W-1:0] r_bin;
    logic [u2da_pkg::BCD_W-1:0]   r_bcd;
    logic [u2da_pkg::BCD_W-1:0]   w_adj;
    logic                         w_digits_ok;
    logic [3:0]                   w_top;
    logic                         r_out_valid;
    logic [u2da_pkg::CHAR_W-1:0]  r_out_char;
    logic                         r_out_last;

    // Each BCD digit of five or more gets three added before the shift.
    always_comb begin
        w_digits_ok = 1'b1;
        for (int i = 0; i < u2da_pkg::NUM_DIGITS; i++) begin
            w_adj[4*i +: 4] = (r_bcd[4*i +: 4] >= 4'd5) ? r_bcd[4*i +: 4] + 4'd3
                                                         : r_bcd[4*i +: 4];
            if (r_bcd[4*i +: 4] > 4'd9) begin
                w_digits_ok = 1'b0;
            end
        end
    end

    assign w_top = r_bcd[u2da_pkg::BCD_W-1 -: 4];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_bin <= i_value;
            r_bcd <= '0;
        end else if (i_cmd.step) begin
            r_bcd <= {w_adj[u2da_pkg::BCD_W-2:0], r_bin[u2da_pkg::VALUE_W-1]};
            r_bin <= {r_bin[u2da_pkg::VALUE_W-2:0], 1'b0};
        end else if (i_cmd.drop || i_cmd.emit) begin
            r_bcd <= {r_bcd[u2da_pkg::BCD_W-5:0], 4'd0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_out_char <= u2da_pkg::DIGIT_BASE + {2'b00, w_top};
            r_out_last <= i_cmd.last;
        end
    end

    assign o_status.top_zero = (w_top == 4'd0);
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_char        = r_out_char;
    assign o_out_last        = r_out_last;

    a_step_bcd_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.step |-> w_digits_ok)
        else $error("BCD digit out of range during conversion step");

endmodule
`default_nettype wire

/* rtl/u2da_ctrl.sv */
// Controller: sequences load, conversion steps, leading zero skip and digit output.
`default_nettype none
module u2da_ctrl (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_ready,
    input  wire u2da_pkg::t_dp_status   i_status,
    output u2da_pkg::t_dp_cmd           o_cmd
);

    u2da_pkg::t_state                  r_state, n_state;
    logic [u2da_pkg::CNT_W-1:0]        r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= u2da_pkg::ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            u2da_pkg::ST_IDLE: begin
                if (i_in_valid) n_state = u2da_pkg::ST_CONV;
            end
            u2da_pkg::ST_CONV: begin
                if (r_cnt == u2da_pkg::LAST_STEP) n_state = u2da_pkg::ST_SKIP;
            end
            u2da_pkg::ST_SKIP: begin
                if (!i_status.top_zero || r_cnt == '0) n_state = u2da_pkg::ST_EMIT;
            end
            u2da_pkg::ST_EMIT: begin
                if (i_status.out_free && r_cnt == '0) n_state = u2da_pkg::ST_IDLE;
            end
            default: n_state = u2da_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        n_cnt      = r_cnt;
        case (r_state)
            u2da_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
                n_cnt      = '0;
            end
            u2da_pkg::ST_CONV: begin
                o_cmd.step = 1'b1;
                n_cnt      = (r_cnt == u2da_pkg::LAST_STEP) ? u2da_pkg::TOP_DIGIT
                                                            : r_cnt + 1'b1;
            end
            u2da_pkg::ST_SKIP: begin
                if (i_status.top_zero && r_cnt != '0) begin
                    o_cmd.drop = 1'b1;
                    n_cnt      = r_cnt - 1'b1;
                end
            end
            u2da_pkg::ST_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = (r_cnt == '0);
                    if (r_cnt != '0) n_cnt = r_cnt - 1'b1;
                end
            end
            default: begin
                n_cnt = '0;
            end
        endcase
    end

endmodule
`default_nettype wire

/* rtl/unsigned_to_decimal_ascii_core.sv */
// Top level of the 32-bit unsigned binary to decimal ASCII converter.
//
// The slave stream takes one 32-bit unsigned value per transaction. The master
// stream returns its decimal digits as ASCII characters, most significant first,
// with leading zeros removed; a zero value gives the single character '0'.
// The final character of each run is flagged with m_axis_tlast.
// After a value is accepted, shift-and-add-3 conversion steps, one per input
// bit, build the BCD digits; each suppressed leading zero is then dropped,
// the controller settles on the first digit, and the digits enter the output
// register in turn. Skipped zeros and emitted digits always total ten.
// s_axis_tready stays low until the final digit has entered the output
// register, so no new value is taken while one is still being converted.
// When the receiver stalls, the current character is held in the output
// register and digit output pauses until the transaction completes.
// Reset clears the controller and the output valid flag; any run in progress
// is dropped.
`default_nettype none
module unsigned_to_decimal_ascii_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [7:0]       m_axis_tdata,   // [5:0] digit_char, [7:6] zero
    output logic             m_axis_tlast    // last_digit
);

    u2da_pkg::t_dp_cmd               w_cmd;
    u2da_pkg::t_dp_status            w_status;
    logic [u2da_pkg::CHAR_W-1:0]     w_char;

    u2da_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    u2da_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_value     (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_char  (w_char),
        .o_out_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {2'b00, w_char};

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("Input accepted while a conversion is in progress");

    a_char_is_digit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata >= 8'd48 && m_axis_tdata <= 8'd57))
        else $error("Output character is not a decimal digit");

    a_idle_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cmd.emit && w_cmd.last) |=> s_axis_tready)
        else $error("Converter not idle after the final digit was issued");

endmodule
`default_nettype wire
